// File: src/yafq_pkg.sv
package yafq_pkg;

  localparam int unsigned NUM_LANES = 4;

  localparam logic [8:0] ALPHA_RESET = 9'd256;
  localparam logic [8:0] ALPHA_MAX   = 9'd256;

  localparam logic signed [19:0] LUMA_OFS   = 20'sd16;
  localparam logic signed [19:0] CHROMA_OFS = 20'sd128;

  localparam logic signed [19:0] C_Y  = 20'sd298;
  localparam logic signed [19:0] C_RV = 20'sd408;
  localparam logic signed [19:0] C_GU = 20'sd100;
  localparam logic signed [19:0] C_GV = 20'sd208;
  localparam logic signed [19:0] C_BU = 20'sd516;

  localparam logic signed [19:0] C_YR = 20'sd65;
  localparam logic signed [19:0] C_YG = 20'sd129;
  localparam logic signed [19:0] C_YB = 20'sd25;
  localparam logic signed [19:0] C_UR = 20'sd37;
  localparam logic signed [19:0] C_UG = 20'sd74;
  localparam logic signed [19:0] C_UB = 20'sd112;
  localparam logic signed [19:0] C_VR = 20'sd112;
  localparam logic signed [19:0] C_VG = 20'sd94;
  localparam logic signed [19:0] C_VB = 20'sd18;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } stage_en_t;

  function automatic logic [7:0] sat8(input logic signed [19:0] x);
    logic [7:0] res;
    if (x < 20'sd0) begin
      res = 8'd0;
    end else if (x > 20'sd255) begin
      res = 8'd255;
    end else begin
      res = x[7:0];
    end
    return res;
  endfunction

  function automatic logic signed [19:0] ext8(input logic [7:0] x);
    return signed'({12'd0, x});
  endfunction

endpackage

// File: src/yafq_lane.sv
module yafq_lane (
  input  logic                  clk,
  input  yafq_pkg::stage_en_t   en,
  input  logic [7:0]            luma,
  input  logic [7:0]            chroma_blue,
  input  logic [7:0]            chroma_red,
  input  logic [8:0]            fade,
  output logic [7:0]            new_luma,
  output logic [7:0]            new_blue,
  output logic [7:0]            new_red
);

  logic signed [19:0] yd, ud, vd, base;
  logic signed [19:0] r_sum, g_sum, b_sum;
  logic [7:0]  r1_r, g1_r, b1_r, r1_nxt, g1_nxt, b1_nxt;
  logic [16:0] rp, gp, bp;
  logic [7:0]  r2_r, g2_r, b2_r;
  logic signed [19:0] r2, g2, b2, y_sum, u_sum, v_sum;
  logic [7:0]  y3_r, u3_r, v3_r, y3_nxt, u3_nxt, v3_nxt;

  // yuv to rgb
  always_comb begin
    yd     = yafq_pkg::ext8(luma) - yafq_pkg::LUMA_OFS;
    ud     = yafq_pkg::ext8(chroma_blue) - yafq_pkg::CHROMA_OFS;
    vd     = yafq_pkg::ext8(chroma_red) - yafq_pkg::CHROMA_OFS;
    base   = yafq_pkg::C_Y * yd;
    r_sum  = base + yafq_pkg::C_RV * vd;
    g_sum  = base - yafq_pkg::C_GU * ud - yafq_pkg::C_GV * vd;
    b_sum  = base + yafq_pkg::C_BU * ud;
    r1_nxt = yafq_pkg::sat8(r_sum >>> 8);
    g1_nxt = yafq_pkg::sat8(g_sum >>> 8);
    b1_nxt = yafq_pkg::sat8(b_sum >>> 8);
  end

  always_ff @(posedge clk) begin
    if (en.s1) begin
      r1_r <= r1_nxt;
      g1_r <= g1_nxt;
      b1_r <= b1_nxt;
    end
  end

  // fade
  assign rp = {9'd0, r1_r} * {8'd0, fade};
  assign gp = {9'd0, g1_r} * {8'd0, fade};
  assign bp = {9'd0, b1_r} * {8'd0, fade};

  always_ff @(posedge clk) begin
    if (en.s2) begin
      r2_r <= rp[15:8];
      g2_r <= gp[15:8];
      b2_r <= bp[15:8];
    end
  end

  // rgb back to yuv
  always_comb begin
    r2     = yafq_pkg::ext8(r2_r);
    g2     = yafq_pkg::ext8(g2_r);
    b2     = yafq_pkg::ext8(b2_r);
    y_sum  = yafq_pkg::C_YR * r2 + yafq_pkg::C_YG * g2 + yafq_pkg::C_YB * b2;
    u_sum  = yafq_pkg::C_UB * b2 - yafq_pkg::C_UR * r2 - yafq_pkg::C_UG * g2;
    v_sum  = yafq_pkg::C_VR * r2 - yafq_pkg::C_VG * g2 - yafq_pkg::C_VB * b2;
    y3_nxt = yafq_pkg::sat8((y_sum >>> 8) + yafq_pkg::LUMA_OFS);
    u3_nxt = yafq_pkg::sat8((u_sum >>> 8) + yafq_pkg::CHROMA_OFS);
    v3_nxt = yafq_pkg::sat8((v_sum >>> 8) + yafq_pkg::CHROMA_OFS);
  end

  always_ff @(posedge clk) begin
    if (en.s3) begin
      y3_r <= y3_nxt;
      u3_r <= u3_nxt;
      v3_r <= v3_nxt;
    end
  end

  assign new_luma = y3_r;
  assign new_blue = u3_r;
  assign new_red  = v3_r;

endmodule

// File: src/yafq_merge.sv
module yafq_merge (
  input  logic       clk,
  input  logic       en,
  input  logic [7:0] lane_luma [yafq_pkg::NUM_LANES],
  input  logic [7:0] lane_blue [yafq_pkg::NUM_LANES],
  input  logic [7:0] lane_red  [yafq_pkg::NUM_LANES],
  output logic [7:0] luma_out  [yafq_pkg::NUM_LANES],
  output logic [7:0] blue_out,
  output logic [7:0] red_out
);

  logic [7:0] luma_r [yafq_pkg::NUM_LANES];
  logic [7:0] blue_r, red_r, blue_nxt, red_nxt;

  // sum of quartered chroma
  always_comb begin
    blue_nxt = 8'd0;
    red_nxt  = 8'd0;
    for (int i = 0; i < yafq_pkg::NUM_LANES; i++) begin
      blue_nxt = blue_nxt + {2'b00, lane_blue[i][7:2]};
      red_nxt  = red_nxt + {2'b00, lane_red[i][7:2]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      luma_r <= lane_luma;
      blue_r <= blue_nxt;
      red_r  <= red_nxt;
    end
  end

  assign luma_out = luma_r;
  assign blue_out = blue_r;
  assign red_out  = red_r;

endmodule

// File: src/yuv420_alpha_fade_quad_unit.sv
// the result passes through three lane stages and the merge register
// one quad per cycle while not stalled; four lanes convert the four pixels side by side
// each stage holds its request while the next one is full and stalled, so a stalled result
// still lets earlier stages fill
// reset (rst_n low, synchronous) empties the pipeline and sets alpha_level to 256
module yuv420_alpha_fade_quad_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [8:0] cfg_alpha_level,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_luma_top_left,
  input  logic [7:0] in_luma_top_right,
  input  logic [7:0] in_luma_bottom_left,
  input  logic [7:0] in_luma_bottom_right,
  input  logic [7:0] in_chroma_blue_in,
  input  logic [7:0] in_chroma_red_in,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_new_luma_top_left,
  output logic [7:0] out_new_luma_top_right,
  output logic [7:0] out_new_luma_bottom_left,
  output logic [7:0] out_new_luma_bottom_right,
  output logic [7:0] out_chroma_blue_out,
  output logic [7:0] out_chroma_red_out
);

  logic [8:0] alpha_r;
  logic [8:0] fade;
  logic v1_r, v2_r, v3_r, vo_r;
  logic rdy1, rdy2, rdy3, rdyo;
  yafq_pkg::stage_en_t en;
  logic [7:0] luma_in   [yafq_pkg::NUM_LANES];
  logic [7:0] lane_luma [yafq_pkg::NUM_LANES];
  logic [7:0] lane_blue [yafq_pkg::NUM_LANES];
  logic [7:0] lane_red  [yafq_pkg::NUM_LANES];
  logic [7:0] luma_out  [yafq_pkg::NUM_LANES];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alpha_r <= yafq_pkg::ALPHA_RESET;
    end else if (cfg_valid) begin
      alpha_r <= cfg_alpha_level;
    end
  end

  assign fade = (alpha_r > yafq_pkg::ALPHA_MAX) ? yafq_pkg::ALPHA_MAX : alpha_r;

  assign rdyo = !vo_r || out_ready;
  assign rdy3 = !v3_r || rdyo;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_ready = rdy1;

  assign en.s1 = rdy1;
  assign en.s2 = rdy2;
  assign en.s3 = rdy3;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
      if (rdyo) begin
        vo_r <= v3_r;
      end
    end
  end

  assign luma_in[0] = in_luma_top_left;
  assign luma_in[1] = in_luma_top_right;
  assign luma_in[2] = in_luma_bottom_left;
  assign luma_in[3] = in_luma_bottom_right;

  for (genvar i = 0; i < yafq_pkg::NUM_LANES; i++) begin : g_lane
    yafq_lane u_lane (
      .clk         (clk),
      .en          (en),
      .luma        (luma_in[i]),
      .chroma_blue (in_chroma_blue_in),
      .chroma_red  (in_chroma_red_in),
      .fade        (fade),
      .new_luma    (lane_luma[i]),
      .new_blue    (lane_blue[i]),
      .new_red     (lane_red[i])
    );
  end

  yafq_merge u_merge (
    .clk       (clk),
    .en        (rdyo),
    .lane_luma (lane_luma),
    .lane_blue (lane_blue),
    .lane_red  (lane_red),
    .luma_out  (luma_out),
    .blue_out  (out_chroma_blue_out),
    .red_out   (out_chroma_red_out)
  );

  assign out_valid                 = vo_r;
  assign out_new_luma_top_left     = luma_out[0];
  assign out_new_luma_top_right    = luma_out[1];
  assign out_new_luma_bottom_left  = luma_out[2];
  assign out_new_luma_bottom_right = luma_out[3];

endmodule
